// File: rtl/core/cdq_pkg.sv
// shared types and constants for the circular double-ended queue
package cdq_pkg;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/core/cdq_if.sv
// request and response channel interfaces
interface cdq_in_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] data;

    modport source (output valid, output op, output data, input ready);
    modport sink   (input valid, input op, input data, output ready);
endinterface

interface cdq_out_if #(
    parameter int CNT_W = 5
);
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic [CNT_W-1:0]         occupancy;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output status, output front_value, output rear_value,
                    output occupancy, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input front_value, input rear_value,
                    input occupancy, input is_empty, input is_full, output ready);
endinterface

// File: rtl/core/circular_double_ended_queue.sv
// top level of the circular double-ended queue
//
// i_req carries one request: op (push front, push rear, pop front, pop rear,
// query; unused codes act as query) and data for pushes. o_rsp returns one
// response per request: status (ok, overflow, underflow), the front and rear
// values after the operation (all ones when empty), the occupancy and the
// empty and full flags.
// a request, once accepted, goes through index and count update with the
// slot write, slot memory read of front and rear, and load of the output
// register. one request is in flight at a time, so a new request is not
// accepted until the one before it has loaded the output register.
// the response sits in an output register; while it waits, the next request
// is accepted and worked, and holds in its last step until the register is
// taken.
// reset clears the indices, the count and the response valid; slot contents
// are undefined until written and are never read before that, so there is
// no clearing pass.
module circular_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cdq_in_if.sink       i_req,
    cdq_out_if.source    o_rsp
);
    import cdq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    cdq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(w_in_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    cdq_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (i_req.op),
        .i_data       (i_req.data),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_front_value(o_rsp.front_value),
        .o_rear_value (o_rsp.rear_value),
        .o_occupancy  (o_rsp.occupancy),
        .o_is_empty   (o_rsp.is_empty),
        .o_is_full    (o_rsp.is_full)
    );

    assign i_req.ready = w_in_ready;

    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("response register overwritten while pending");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.is_empty == (o_rsp.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.is_empty) |-> (o_rsp.front_value == '1 &&
                                             o_rsp.rear_value == '1))
        else $error("empty response does not read all ones");
endmodule

// File: rtl/core/cdq_ram.sv
// generic ram, one write port and two registered read ports
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// File: rtl/core/cdq_ctrl.sv
// control state machine sequencing one request at a time
module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cdq_pkg::t_dp_sts i_sts,
    output cdq_pkg::t_dp_cmd o_cmd
);
    import cdq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// File: rtl/core/cdq_dp.sv
// datapath: indices, count, slot memory and output register
module cdq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cdq_pkg::t_dp_cmd                    i_cmd,
    output cdq_pkg::t_dp_sts                    o_sts,
    input  logic [cdq_pkg::OP_W-1:0]            i_op,
    input  logic signed [cdq_pkg::DATA_W-1:0]   i_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [cdq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [cdq_pkg::DATA_W-1:0]   o_front_value,
    output logic signed [cdq_pkg::DATA_W-1:0]   o_rear_value,
    output logic [$clog2(DEPTH+1)-1:0]          o_occupancy,
    output logic                                o_is_empty,
    output logic                                o_is_full
);
    import cdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [IW-1:0] f_up(input logic [IW-1:0] i);
        return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] f_dn(input logic [IW-1:0] i);
        return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
    endfunction

    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_data;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    t_status           r_status, n_status;

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_front;
    logic [DATA_W-1:0] w_rear;
    logic              w_full;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_front;
    logic [DATA_W-1:0]   r_out_rear;
    logic [CW-1:0]       r_out_count;
    logic                r_out_empty;
    logic                r_out_full;

    assign w_full = (r_count == CW'(DEPTH));

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_tail;
        if (i_cmd.exec) begin
            n_status = ST_OK;
            case (r_op)
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_head  = f_dn(r_head);
                        w_waddr = f_dn(r_head);
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_PUSH_REAR: begin
                    if (w_full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        w_we    = 1'b1;
                        n_tail  = f_up(r_tail);
                        n_count = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_head  = f_up(r_head);
                        n_count = r_count - 1'b1;
                    end
                end
                OP_POP_REAR: begin
                    if (r_count == '0) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_tail  = f_dn(r_tail);
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_data <= i_data;
        end
    end

    cdq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (r_data),
        .i_raddr_a(r_head),
        .i_raddr_b(f_dn(r_tail)),
        .o_rdata_a(w_front),
        .o_rdata_b(w_rear)
    );

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= r_status;
            r_out_front  <= (r_count == '0) ? '1 : w_front;
            r_out_rear   <= (r_count == '0) ? '1 : w_rear;
            r_out_count  <= r_count;
            r_out_empty  <= (r_count == '0);
            r_out_full   <= w_full;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_front_value  = r_out_front;
    assign o_rear_value   = r_out_rear;
    assign o_occupancy    = r_out_count;
    assign o_is_empty     = r_out_empty;
    assign o_is_full      = r_out_full;
endmodule
